FILE: hw/rtl/ihg_pkg.sv
// shared types and constants for the ipv4 header generator
package ihg_pkg;

   localparam int WORD_COUNT   = 10;
   localparam int WORD_IDX_W   = 4;
   localparam int LEN_W        = 16;
   localparam int PROTO_W      = 8;
   localparam int IDENT_W      = 16;
   localparam int ADDR_W       = 32;
   localparam int HWORD_W      = 16;
   localparam int ADDR_SUM_W   = 19;
   localparam int SUM_W        = 20;
   localparam int CSR_INDEX_W  = 1;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0]         VER_IHL      = 8'h45;
   localparam logic [7:0]         TTL_VALUE    = 8'd64;
   localparam logic [HWORD_W-1:0] VER_IHL_WORD = {VER_IHL, 8'h00};
   localparam logic [HWORD_W-1:0] ZERO_WORD    = 16'h0000;
   localparam logic [HWORD_W-1:0] CONST_SUM    = 16'h8500;
   localparam logic [IDENT_W-1:0] IDENT_RESET  = 16'h0001;

   typedef enum logic [WORD_IDX_W-1:0] {
      WORD_VER      = 4'd0,
      WORD_LEN      = 4'd1,
      WORD_IDENT    = 4'd2,
      WORD_FRAG     = 4'd3,
      WORD_TTL      = 4'd4,
      WORD_CHECKSUM = 4'd5,
      WORD_SRC_HI   = 4'd6,
      WORD_SRC_LO   = 4'd7,
      WORD_DST_HI   = 4'd8,
      WORD_DST_LO   = 4'd9
   } word_sel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_ADDRESS = 1'b0,
      CSR_DEST_ADDRESS   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]   total_length;
      logic [PROTO_W-1:0] protocol;
      logic [IDENT_W-1:0] ident;
      logic [SUM_W-1:0]   sum;
   } entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] dest_address;
   } addr_type;

endpackage

FILE: hw/rtl/ihg_front.sv
// front end: csr registers, request intake, identification and raw checksum sum
module ihg_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ihg_pkg::LEN_W-1:0]           req_total_length,
   input  logic [ihg_pkg::PROTO_W-1:0]         req_protocol,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ihg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ihg_pkg::ADDR_W-1:0]          csr_data,
   input  logic                                queue_full,
   output logic                                push,
   output ihg_pkg::entry_type                  push_entry,
   output ihg_pkg::addr_type                   addr
);

   logic [ihg_pkg::ADDR_W-1:0]     src_ff, src_in;
   logic [ihg_pkg::ADDR_W-1:0]     dst_ff, dst_in;
   logic [ihg_pkg::ADDR_SUM_W-1:0] addr_sum_ff, addr_sum_in;
   logic [ihg_pkg::IDENT_W-1:0]    ident_ff, ident_in;
   logic                           csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // address halves plus the fixed words, kept ready for the checksum
   always_comb begin
      src_in      = src_ff;
      dst_in      = dst_ff;
      addr_sum_in = addr_sum_ff;
      if (csr_write) begin
         case (ihg_pkg::csr_index_type'(csr_index))
            ihg_pkg::CSR_SOURCE_ADDRESS: begin
               src_in      = csr_data;
               addr_sum_in = ihg_pkg::ADDR_SUM_W'(csr_data[31:16])
                           + ihg_pkg::ADDR_SUM_W'(csr_data[15:0])
                           + ihg_pkg::ADDR_SUM_W'(dst_ff[31:16])
                           + ihg_pkg::ADDR_SUM_W'(dst_ff[15:0])
                           + ihg_pkg::ADDR_SUM_W'(ihg_pkg::CONST_SUM);
            end
            ihg_pkg::CSR_DEST_ADDRESS: begin
               dst_in      = csr_data;
               addr_sum_in = ihg_pkg::ADDR_SUM_W'(src_ff[31:16])
                           + ihg_pkg::ADDR_SUM_W'(src_ff[15:0])
                           + ihg_pkg::ADDR_SUM_W'(csr_data[31:16])
                           + ihg_pkg::ADDR_SUM_W'(csr_data[15:0])
                           + ihg_pkg::ADDR_SUM_W'(ihg_pkg::CONST_SUM);
            end
            default: begin
               src_in      = src_ff;
               dst_in      = dst_ff;
               addr_sum_in = addr_sum_ff;
            end
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;
   assign ident_in  = push ? ident_ff + ihg_pkg::IDENT_W'(1) : ident_ff;

   always_comb begin
      push_entry.total_length = req_total_length;
      push_entry.protocol     = req_protocol;
      push_entry.ident        = ident_ff;
      push_entry.sum          = ihg_pkg::SUM_W'(addr_sum_ff)
                              + ihg_pkg::SUM_W'(req_total_length)
                              + ihg_pkg::SUM_W'(ident_ff)
                              + ihg_pkg::SUM_W'(req_protocol);
   end

   assign addr.source_address = src_ff;
   assign addr.dest_address   = dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff      <= '0;
         dst_ff      <= '0;
         addr_sum_ff <= ihg_pkg::ADDR_SUM_W'(ihg_pkg::CONST_SUM);
         ident_ff    <= ihg_pkg::IDENT_RESET;
      end else begin
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         addr_sum_ff <= addr_sum_in;
         ident_ff    <= ident_in;
      end
   end

endmodule

FILE: hw/rtl/ihg_queue.sv
// short fifo of stamped requests between front and back
module ihg_queue #(
   parameter int DEPTH = ihg_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ihg_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ihg_pkg::entry_type pop_entry
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   ihg_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !do_push)
      else $error("push into full queue");

endmodule

FILE: hw/rtl/ihg_back.sv
// back end: walks the ten header words of each queued request into the output register
module ihg_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              entry_valid,
   input  ihg_pkg::entry_type                entry,
   input  ihg_pkg::addr_type                 addr,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ihg_pkg::WORD_IDX_W-1:0]    rsp_word_index,
   output logic [ihg_pkg::HWORD_W-1:0]       rsp_header_word,
   output logic                              rsp_last_word
);

   logic [ihg_pkg::WORD_IDX_W-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic [ihg_pkg::WORD_IDX_W-1:0] index_ff;
   logic [ihg_pkg::HWORD_W-1:0]    word_ff, word_in;
   logic                           last_ff;
   logic                           load, is_last;
   logic [16:0]                    fold1;
   logic [ihg_pkg::HWORD_W-1:0]    fold2;

   assign load    = entry_valid && (!valid_ff || !rsp_stall);
   assign is_last = (idx_ff == ihg_pkg::WORD_IDX_W'(ihg_pkg::WORD_COUNT - 1));
   assign pop     = load && is_last;

   // end-around carry fold of the raw sum
   assign fold1 = 17'(entry.sum[ihg_pkg::SUM_W-1:16]) + 17'(entry.sum[15:0]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);

   always_comb begin
      case (ihg_pkg::word_sel_type'(idx_ff))
         ihg_pkg::WORD_VER:      word_in = ihg_pkg::VER_IHL_WORD;
         ihg_pkg::WORD_LEN:      word_in = entry.total_length;
         ihg_pkg::WORD_IDENT:    word_in = entry.ident;
         ihg_pkg::WORD_FRAG:     word_in = ihg_pkg::ZERO_WORD;
         ihg_pkg::WORD_TTL:      word_in = {ihg_pkg::TTL_VALUE, entry.protocol};
         ihg_pkg::WORD_CHECKSUM: word_in = ~fold2;
         ihg_pkg::WORD_SRC_HI:   word_in = addr.source_address[31:16];
         ihg_pkg::WORD_SRC_LO:   word_in = addr.source_address[15:0];
         ihg_pkg::WORD_DST_HI:   word_in = addr.dest_address[31:16];
         ihg_pkg::WORD_DST_LO:   word_in = addr.dest_address[15:0];
         default:                word_in = ihg_pkg::ZERO_WORD;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + ihg_pkg::WORD_IDX_W'(1);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= idx_ff;
         word_ff  <= word_in;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_word_index  = index_ff;
   assign rsp_header_word = word_ff;
   assign rsp_last_word   = last_ff;

   a_last_matches_index: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == (index_ff == ihg_pkg::WORD_IDX_W'(ihg_pkg::WORD_COUNT - 1))))
      else $error("last word flag does not match word index");

   a_first_word_fixed: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && index_ff == ihg_pkg::WORD_IDX_W'(ihg_pkg::WORD_VER))
         |-> (word_ff == ihg_pkg::VER_IHL_WORD))
      else $error("first header word is not version and ihl");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("request retired without last word");

endmodule

FILE: hw/rtl/ipv4_header_generator.sv
// ipv4 header generator top level
// Each accepted request (total length, protocol) produces a 20-byte IPv4 header as ten
// 16-bit words in network order, one word per cycle from the output register while
// rsp_stall is low, and the back end moves on to the next queued request without a gap.
// The front end takes a request whenever its queue (QUEUE_DEPTH entries) has room,
// stamps it with the identification counter (1 after reset, wrapping) and forms the
// raw checksum sum; the first word of a request passes through a queue entry and then
// the output register. Source and destination addresses are written through the csr
// port (index 0 source, 1 destination); the user must write them only while no header
// is in flight, which the block itself does not enforce. csr_ready is always high.
module ipv4_header_generator #(
   parameter int QUEUE_DEPTH = ihg_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ihg_pkg::LEN_W-1:0]         req_total_length,
   input  logic [ihg_pkg::PROTO_W-1:0]       req_protocol,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ihg_pkg::WORD_IDX_W-1:0]    rsp_word_index,
   output logic [ihg_pkg::HWORD_W-1:0]       rsp_header_word,
   output logic                              rsp_last_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ihg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ihg_pkg::ADDR_W-1:0]        csr_data
);

   logic               queue_full;
   logic               push;
   ihg_pkg::entry_type push_entry;
   logic               pop;
   logic               not_empty;
   ihg_pkg::entry_type pop_entry;
   ihg_pkg::addr_type  addr;

   ihg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_total_length (req_total_length),
      .req_protocol     (req_protocol),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry),
      .addr             (addr)
   );

   ihg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .pop_entry  (pop_entry)
   );

   ihg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .entry_valid     (not_empty),
      .entry           (pop_entry),
      .addr            (addr),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word_index  (rsp_word_index),
      .rsp_header_word (rsp_header_word),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
